>>> rtl/mpsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mpsd_pkg;
   localparam int COORD_WIDTH = 32;
   localparam int MAX_POINTS  = 8;
   localparam int INDEX_WIDTH = 3;
   localparam int DIST_WIDTH  = 32;
   localparam int T_BITS      = 30;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int WIDE_WIDTH  = PROD_WIDTH + 2;
   localparam int SUM_WIDTH   = 64;
   localparam int STEP_WIDTH  = 7;
   localparam logic [WIDE_WIDTH-1:0] SHORT_LEN2 = WIDE_WIDTH'(4);

   localparam logic [2:0] REG_BOTTOM_X = 3'd0;
   localparam logic [2:0] REG_BOTTOM_Y = 3'd1;
   localparam logic [2:0] REG_BOTTOM_Z = 3'd2;
   localparam logic [2:0] REG_TOP_X    = 3'd3;
   localparam logic [2:0] REG_TOP_Y    = 3'd4;
   localparam logic [2:0] REG_TOP_Z    = 3'd5;
   localparam logic [2:0] REG_LIMIT    = 3'd6;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
      logic                          last_point;
   } req_type;

   typedef struct packed {
      logic [DIST_WIDTH-1:0]         best_distance;
      logic signed [COORD_WIDTH-1:0] blade_x;
      logic signed [COORD_WIDTH-1:0] blade_y;
      logic signed [COORD_WIDTH-1:0] blade_z;
      logic signed [COORD_WIDTH-1:0] throat_x;
      logic signed [COORD_WIDTH-1:0] throat_y;
      logic signed [COORD_WIDTH-1:0] throat_z;
      logic [INDEX_WIDTH-1:0]        match_index;
      logic                          match_valid;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIFF, ST_MUL, ST_ACC, ST_DECIDE, ST_DIV, ST_OFFSET,
      ST_SQ_BLADE, ST_ROOT_BLADE, ST_SQ_TOP, ST_ROOT_TOP, ST_FINISH, ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic load;
      logic diff;
      logic mul;
      logic acc;
      logic decide;
      logic div_step;
      logic offset;
      logic sq_blade;
      logic sq_top;
      logic root_step;
      logic cmp_blade;
      logic cmp_top;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic step_done;
      logic need_div;
      logic last;
   } status_type;
endpackage
`default_nettype wire

>>> rtl/min_point_to_segment_distance.sv
`timescale 1ns / 1ps
`default_nettype none
// min_point_to_segment_distance
// req channel: one query point per transaction, last_point closes the run
// rsp channel: one transaction per run, sent after the last point
// csr channel: register writes, always ready; index 0..2 bottom, 3..5 top,
//    6 contact_limit
// each point runs through the shared datapath in order: an accept step,
// the difference, multiply, accumulate and decide steps, restoring
// division and offset for t when the projection falls inside the segment,
// square and root passes for the blade and the top end, and a finish step
// one point is processed at a time; req_ready is high only when idle
// the result holds in its registers until rsp_ready; no new point is
// taken while the result waits
// reset clears segment registers to zero, contact_limit to all ones
// and opens a fresh run
module min_point_to_segment_distance (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mpsd_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mpsd_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_data
);
   import mpsd_pkg::*;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   mpsd_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   mpsd_datapath u_dp (
      .clock, .reset, .req_payload, .csr_valid, .csr_index, .csr_data,
      .cmd, .status, .rsp_payload
   );
endmodule
`default_nettype wire

>>> rtl/mpsd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mpsd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire mpsd_pkg::status_type status,
   output mpsd_pkg::cmd_type         cmd
);
   import mpsd_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = status.need_div ? ST_DIV : ST_SQ_BLADE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.step_done) state_in = ST_OFFSET;
         end
         ST_OFFSET: begin
            cmd.offset = 1'b1;
            state_in   = ST_SQ_BLADE;
         end
         ST_SQ_BLADE: begin
            cmd.sq_blade = 1'b1;
            state_in     = ST_ROOT_BLADE;
         end
         ST_ROOT_BLADE: begin
            cmd.root_step = 1'b1;
            if (status.step_done) begin
               cmd.cmp_blade = 1'b1;
               state_in      = ST_SQ_TOP;
            end
         end
         ST_SQ_TOP: begin
            cmd.sq_top = 1'b1;
            state_in   = ST_ROOT_TOP;
         end
         ST_ROOT_TOP: begin
            cmd.root_step = 1'b1;
            if (status.step_done) begin
               cmd.cmp_top = 1'b1;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = status.last ? ST_OUTPUT : ST_IDLE;
            if (!status.last) cmd.finish = 1'b1;
         end
         ST_OUTPUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

>>> rtl/mpsd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module mpsd_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mpsd_pkg::req_type    req_payload,
   input  wire logic                 csr_valid,
   input  wire logic [2:0]           csr_index,
   input  wire logic [31:0]          csr_data,
   input  wire mpsd_pkg::cmd_type    cmd,
   output mpsd_pkg::status_type      status,
   output mpsd_pkg::rsp_type         rsp_payload
);
   import mpsd_pkg::*;

   logic signed [COORD_WIDTH-1:0] bot_ff [3];
   logic signed [COORD_WIDTH-1:0] top_ff [3];
   logic [DIST_WIDTH-1:0]         limit_ff;
   logic                          open_ff;

   logic signed [COORD_WIDTH-1:0] p_ff [3];
   logic                          last_ff;
   logic [DIFF_WIDTH-1:0]         me_ff [3];
   logic [DIFF_WIDTH-1:0]         md_ff [3];
   logic                          ne_ff [3];
   logic                          nd_ff [3];
   logic [PROD_WIDTH-1:0]         ee_ff [3];
   logic [PROD_WIDTH-1:0]         ed_ff [3];
   logic [WIDE_WIDTH-1:0]         len2_ff, rem_ff;
   logic [T_BITS-1:0]             t_ff;
   logic [STEP_WIDTH-1:0]         step_ff;
   logic signed [COORD_WIDTH-1:0] blade_ff [3];
   logic [SUM_WIDTH-1:0]          rad_ff, res_ff, bit_ff;

   logic [DIST_WIDTH-1:0]         best_ff;
   logic signed [COORD_WIDTH-1:0] rblade_ff [3];
   logic signed [COORD_WIDTH-1:0] rthroat_ff [3];
   logic [INDEX_WIDTH-1:0]        ridx_ff, cnt_ff;
   logic                          rvalid_ff;

   logic [WIDE_WIDTH-1:0] pos_w, neg_w, rem_sh;
   logic [PROD_WIDTH-1:0] sq [3];
   logic [DIFF_WIDTH-1:0] dm [3];
   logic signed [DIFF_WIDTH-1:0] dd [3];
   logic [SUM_WIDTH-1:0]  trial;
   logic [SUM_WIDTH-1:0]  res_next;
   logic [DIST_WIDTH-1:0] root_d;
   logic                  sq_sel_top;

   always_comb begin
      pos_w = '0;
      neg_w = '0;
      for (int i = 0; i < 3; i++) begin
         if (ne_ff[i] != nd_ff[i]) neg_w = neg_w + WIDE_WIDTH'(ed_ff[i]);
         else pos_w = pos_w + WIDE_WIDTH'(ed_ff[i]);
      end
      rem_sh     = {rem_ff[WIDE_WIDTH-2:0], 1'b0};
      sq_sel_top = cmd.sq_top;
      for (int i = 0; i < 3; i++) begin
         dd[i] = sq_sel_top ? (DIFF_WIDTH'(p_ff[i]) - DIFF_WIDTH'(top_ff[i]))
                            : (DIFF_WIDTH'(blade_ff[i]) - DIFF_WIDTH'(p_ff[i]));
         dm[i] = dd[i][DIFF_WIDTH-1] ? DIFF_WIDTH'(-dd[i]) : DIFF_WIDTH'(dd[i]);
      end
      for (int i = 0; i < 3; i++) sq[i] = ee_ff[i];
      trial    = res_ff + bit_ff;
      res_next = (rad_ff >= trial) ? (res_ff >> 1) + bit_ff : res_ff >> 1;
      root_d   = res_next[DIST_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            bot_ff[i]     <= '0;
            top_ff[i]     <= '0;
            rblade_ff[i]  <= '0;
            rthroat_ff[i] <= '0;
         end
         limit_ff  <= '1;
         best_ff   <= '1;
         open_ff   <= 1'b0;
         ridx_ff   <= '0;
         cnt_ff    <= '0;
         rvalid_ff <= 1'b0;
         step_ff   <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_BOTTOM_X, REG_BOTTOM_Y, REG_BOTTOM_Z:
                  bot_ff[2'(csr_index)] <= csr_data;
               REG_TOP_X: top_ff[0] <= csr_data;
               REG_TOP_Y: top_ff[1] <= csr_data;
               REG_TOP_Z: top_ff[2] <= csr_data;
               REG_LIMIT: begin
                  limit_ff <= csr_data;
                  if (!open_ff) best_ff <= csr_data;
               end
               default: ;
            endcase
         end
         if (cmd.load) begin
            p_ff[0] <= req_payload.point_x;
            p_ff[1] <= req_payload.point_y;
            p_ff[2] <= req_payload.point_z;
            last_ff <= req_payload.last_point;
            open_ff <= 1'b1;
         end
         if (cmd.diff) begin
            for (int i = 0; i < 3; i++) begin
               logic signed [DIFF_WIDTH-1:0] e, d;
               e = DIFF_WIDTH'(top_ff[i]) - DIFF_WIDTH'(bot_ff[i]);
               d = DIFF_WIDTH'(p_ff[i]) - DIFF_WIDTH'(bot_ff[i]);
               ne_ff[i] <= e[DIFF_WIDTH-1];
               nd_ff[i] <= d[DIFF_WIDTH-1];
               me_ff[i] <= e[DIFF_WIDTH-1] ? DIFF_WIDTH'(-e) : DIFF_WIDTH'(e);
               md_ff[i] <= d[DIFF_WIDTH-1] ? DIFF_WIDTH'(-d) : DIFF_WIDTH'(d);
            end
         end
         if (cmd.mul) begin
            for (int i = 0; i < 3; i++) begin
               ee_ff[i] <= me_ff[i] * me_ff[i];
               ed_ff[i] <= me_ff[i] * md_ff[i];
            end
         end
         if (cmd.acc) begin
            len2_ff <= WIDE_WIDTH'(sq[0]) + WIDE_WIDTH'(sq[1]) + WIDE_WIDTH'(sq[2]);
            rem_ff  <= (pos_w <= neg_w) ? '0 : pos_w - neg_w;
            for (int i = 0; i < 3; i++) blade_ff[i] <= bot_ff[i];
         end
         if (cmd.decide) begin
            step_ff <= '0;
            t_ff    <= '0;
            if (len2_ff < SHORT_LEN2 || rem_ff == '0) begin
               for (int i = 0; i < 3; i++) blade_ff[i] <= bot_ff[i];
            end else if (rem_ff >= len2_ff) begin
               for (int i = 0; i < 3; i++) blade_ff[i] <= top_ff[i];
            end
         end
         if (cmd.div_step) begin
            step_ff <= step_ff + 1'b1;
            if (rem_sh >= len2_ff) begin
               rem_ff <= rem_sh - len2_ff;
               t_ff   <= {t_ff[T_BITS-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               t_ff   <= {t_ff[T_BITS-2:0], 1'b0};
            end
         end
         if (cmd.offset) begin
            for (int i = 0; i < 3; i++) begin
               logic [DIFF_WIDTH+T_BITS-1:0] prod;
               logic [COORD_WIDTH-1:0] off;
               prod = me_ff[i] * t_ff;
               off  = prod[T_BITS +: COORD_WIDTH];
               blade_ff[i] <= ne_ff[i] ? bot_ff[i] - off : bot_ff[i] + off;
            end
         end
         if (cmd.sq_blade || cmd.sq_top) begin
            logic [SUM_WIDTH+1:0] s;
            s = '0;
            for (int i = 0; i < 3; i++) s = s + (SUM_WIDTH+2)'(dm[i] * dm[i]);
            rad_ff  <= (s[SUM_WIDTH+1:SUM_WIDTH] != 2'b0) ? '1 : s[SUM_WIDTH-1:0];
            res_ff  <= '0;
            bit_ff  <= SUM_WIDTH'(1) << (SUM_WIDTH - 2);
            step_ff <= '0;
         end
         if (cmd.root_step) begin
            step_ff <= step_ff + 1'b1;
            bit_ff  <= bit_ff >> 2;
            if (rad_ff >= trial) begin
               rad_ff <= rad_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
         end
         if (cmd.cmp_blade && root_d < best_ff) begin
            best_ff   <= root_d;
            ridx_ff   <= cnt_ff;
            rvalid_ff <= 1'b1;
            for (int i = 0; i < 3; i++) begin
               rblade_ff[i]  <= blade_ff[i];
               rthroat_ff[i] <= p_ff[i];
            end
         end
         if (cmd.cmp_top && root_d < best_ff) begin
            best_ff   <= root_d;
            ridx_ff   <= cnt_ff;
            rvalid_ff <= 1'b1;
            for (int i = 0; i < 3; i++) begin
               rblade_ff[i]  <= top_ff[i];
               rthroat_ff[i] <= p_ff[i];
            end
         end
         if (cmd.finish) begin
            if (last_ff) begin
               best_ff   <= limit_ff;
               ridx_ff   <= '0;
               cnt_ff    <= '0;
               rvalid_ff <= 1'b0;
               open_ff   <= 1'b0;
               for (int i = 0; i < 3; i++) begin
                  rblade_ff[i]  <= '0;
                  rthroat_ff[i] <= '0;
               end
            end else if (cnt_ff != INDEX_WIDTH'(MAX_POINTS - 1)) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      status.last      = last_ff;
      status.need_div  = !(len2_ff < SHORT_LEN2 || rem_ff == '0 || rem_ff >= len2_ff);
      status.step_done = cmd.div_step ? (step_ff == STEP_WIDTH'(T_BITS - 1))
                                      : (step_ff == STEP_WIDTH'(SUM_WIDTH/2 - 1));
      rsp_payload.best_distance = best_ff;
      rsp_payload.blade_x       = rblade_ff[0];
      rsp_payload.blade_y       = rblade_ff[1];
      rsp_payload.blade_z       = rblade_ff[2];
      rsp_payload.throat_x      = rthroat_ff[0];
      rsp_payload.throat_y      = rthroat_ff[1];
      rsp_payload.throat_z      = rthroat_ff[2];
      rsp_payload.match_index   = ridx_ff;
      rsp_payload.match_valid   = rvalid_ff;
   end
endmodule
`default_nettype wire

>>> verif/tb_min_point_to_segment_distance.sv
`timescale 1ns / 1ps
module tb_min_point_to_segment_distance;
   import mpsd_pkg::*;

   class segment_scoreboard;
      logic [63:0] bot [3];
      logic [63:0] top [3];
      logic [31:0] limit;
      logic [31:0] best_d;
      logic [63:0] best_blade [3];
      logic [63:0] best_throat [3];
      logic [2:0]  best_idx;
      logic        found;
      logic [2:0]  pos_count;
      logic        open_run;
      rsp_type     expect_q [$];
      int          errors;
      int          checked;

      function new();
         errors = 0;
         checked = 0;
         for (int i = 0; i < 3; i++) begin
            bot[i] = '0;
            top[i] = '0;
         end
         limit = '1;
         clear_run();
      endfunction

      function void clear_run();
         best_d = limit;
         for (int i = 0; i < 3; i++) begin
            best_blade[i] = '0;
            best_throat[i] = '0;
         end
         best_idx = '0;
         found = 1'b0;
         pos_count = '0;
         open_run = 1'b0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] data);
         logic [63:0] sx;
         sx = {{32{data[31]}}, data};
         case (idx)
            REG_BOTTOM_X: bot[0] = sx;
            REG_BOTTOM_Y: bot[1] = sx;
            REG_BOTTOM_Z: bot[2] = sx;
            REG_TOP_X:    top[0] = sx;
            REG_TOP_Y:    top[1] = sx;
            REG_TOP_Z:    top[2] = sx;
            REG_LIMIT: begin
               limit = data;
               if (!open_run) best_d = limit;
            end
            default: ;
         endcase
      endfunction

      function logic [31:0] int_root(logic [63:0] v);
         logic [63:0] res;
         logic [63:0] b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res[31:0];
      endfunction

      function logic [31:0] dist3(logic [63:0] a [3], logic [63:0] b [3]);
         logic [64:0] sum;
         logic [63:0] d;
         logic [63:0] m;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            d = a[i] - b[i];
            m = d[63] ? -d : d;
            sum = sum + m * m;
            if (sum[64]) sum = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
         end
         return int_root(sum[63:0]);
      endfunction

      function void nearest(logic [63:0] p [3], output logic [63:0] blade [3]);
         logic [127:0] len2, pos, neg, rem, t, off;
         logic [63:0]  me [3];
         logic         ne [3];
         logic [63:0]  e, q, mq;
         len2 = 0;
         pos = 0;
         neg = 0;
         for (int i = 0; i < 3; i++) begin
            e = top[i] - bot[i];
            ne[i] = e[63];
            me[i] = ne[i] ? -e : e;
            q = p[i] - bot[i];
            mq = q[63] ? -q : q;
            len2 = len2 + me[i] * me[i];
            if (ne[i] != q[63]) neg = neg + me[i] * mq;
            else pos = pos + me[i] * mq;
         end
         if (len2 < 4 || pos <= neg) begin
            blade = bot;
            return;
         end
         rem = pos - neg;
         if (rem >= len2) begin
            blade = top;
            return;
         end
         t = (rem << 30) / len2;
         for (int i = 0; i < 3; i++) begin
            off = (me[i] * t) >> 30;
            blade[i] = bot[i] + (ne[i] ? -off[63:0] : off[63:0]);
         end
      endfunction

      function void take_best(logic [31:0] d, logic [63:0] bl [3], logic [63:0] p [3]);
         if (d < best_d) begin
            best_d = d;
            best_blade = bl;
            best_throat = p;
            best_idx = pos_count;
            found = 1'b1;
         end
      endfunction

      function void note_point(req_type r);
         logic [63:0] p [3];
         logic [63:0] bl [3];
         rsp_type     x;
         p[0] = {{32{r.point_x[31]}}, r.point_x};
         p[1] = {{32{r.point_y[31]}}, r.point_y};
         p[2] = {{32{r.point_z[31]}}, r.point_z};
         open_run = 1'b1;
         nearest(p, bl);
         take_best(dist3(bl, p), bl, p);
         take_best(dist3(p, top), top, p);
         if (!r.last_point) begin
            if (pos_count < MAX_POINTS - 1) pos_count++;
            return;
         end
         x.best_distance = best_d;
         x.blade_x = best_blade[0][31:0];
         x.blade_y = best_blade[1][31:0];
         x.blade_z = best_blade[2][31:0];
         x.throat_x = best_throat[0][31:0];
         x.throat_y = best_throat[1][31:0];
         x.throat_z = best_throat[2][31:0];
         x.match_index = best_idx;
         x.match_valid = found;
         expect_q.push_back(x);
         clear_run();
      endfunction

      function void cmp(string nm, logic [31:0] e, logic [31:0] a);
         if (e !== a) begin
            $display("%0t mismatch %s expected %h actual %h", $time, nm, e, a);
            errors++;
         end
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         checked++;
         if (expect_q.size() == 0) begin
            $display("%0t unexpected result, expected none actual %h", $time, a);
            errors++;
            return;
         end
         e = expect_q.pop_front();
         cmp("best_distance", e.best_distance, a.best_distance);
         cmp("blade_x", e.blade_x, a.blade_x);
         cmp("blade_y", e.blade_y, a.blade_y);
         cmp("blade_z", e.blade_z, a.blade_z);
         cmp("throat_x", e.throat_x, a.throat_x);
         cmp("throat_y", e.throat_y, a.throat_y);
         cmp("throat_z", e.throat_z, a.throat_z);
         cmp("match_index", 32'(e.match_index), 32'(a.match_index));
         cmp("match_valid", 32'(e.match_valid), 32'(a.match_valid));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   segment_scoreboard sb = new();
   bit quiet = 1'b0;
   bit hold_go = 1'b0;
   int points_sent = 0;
   int runs_sent = 0;
   logic [31:0] seg_b [3];
   logic [31:0] seg_t [3];

   min_point_to_segment_distance uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   initial begin
      #16ms;
      $display("timeout");
      $display("Simulation FAILED");
      $finish;
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_payload);
         if (hold_go) begin
            hold_go = 1'b0;
            hold_left = 2000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);
         end
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_segment(logic [31:0] limit);
      write_csr(REG_BOTTOM_X, seg_b[0]);
      write_csr(REG_BOTTOM_Y, seg_b[1]);
      write_csr(REG_BOTTOM_Z, seg_b[2]);
      write_csr(REG_TOP_X, seg_t[0]);
      write_csr(REG_TOP_Y, seg_t[1]);
      write_csr(REG_TOP_Z, seg_t[2]);
      write_csr(REG_LIMIT, limit);
   endtask

   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last);
      req_type r;
      r.point_x = x;
      r.point_y = y;
      r.point_z = z;
      r.last_point = last;
      if (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_point(r);
      points_sent++;
      if (last) runs_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expect_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_coord(int axis);
      logic [31:0] n;
      n = $urandom_range(0, 2047) - 1024;
      case ($urandom_range(9))
         0, 1: return seg_b[axis] + n;
         2, 3: return seg_t[axis] + n;
         4, 5: return seg_b[axis] + ((seg_t[axis] - seg_b[axis]) >>> $urandom_range(1, 4)) + n;
         6: return 32'h8000_0000 + $urandom_range(3);
         7: return 32'h7FFF_FFFF - $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int mode, len;
      logic [31:0] lim;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero-length segment at the origin
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
      send_point(32'h0, 32'h0, 32'h0, 1'b1);
      send_point(32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0010, 1'b1);
      drain();

      // axis segment: middle, before bottom, beyond top, on the top end
      seg_b = '{32'd0, 32'd0, 32'd0};
      seg_t = '{32'd256000, 32'd0, 32'd0};
      set_segment(32'hFFFF_FFFF);
      send_point(32'd128000, 32'd700, 32'd0, 1'b0);
      send_point(-32'd5000, 32'd0, 32'd300, 1'b0);
      send_point(32'd300000, -32'd1, 32'd0, 1'b0);
      send_point(32'd256000, 32'd0, 32'd0, 1'b1);
      // long run, index saturates
      for (int i = 0; i < 11; i++)
         send_point(32'd100 * (11 - i), 32'd50, 32'd7, i == 10);
      drain();

      // no match with a zero limit; extremes saturate the sum of squares
      seg_b = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      seg_t = '{32'h8000_0001, 32'h8000_0000, 32'h8000_0000};
      set_segment(32'h0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      drain();
      write_csr(REG_LIMIT, 32'hFFFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
      drain();

      for (int ph = 0; ph < 14; ph++) begin
         mode = ph % 5;
         for (int a = 0; a < 3; a++) begin
            case (mode)
               0: begin
                  seg_b[a] = $urandom;
                  seg_t[a] = $urandom;
               end
               1: begin
                  seg_b[a] = $urandom_range(0, 8191) - 4096;
                  seg_t[a] = $urandom_range(0, 8191) - 4096;
               end
               2: begin
                  seg_b[a] = $urandom;
                  seg_t[a] = seg_b[a] + ((a == 0) ? $urandom_range(0, 1) : 0);
               end
               3: begin
                  seg_b[a] = 32'h8000_0000;
                  seg_t[a] = 32'h7FFF_FFFF;
               end
               default: begin
                  seg_b[a] = $urandom_range(0, 1 << 20) - (1 << 19);
                  seg_t[a] = seg_b[a] + $urandom_range(0, 1 << 16) - (1 << 15);
               end
            endcase
         end
         case ($urandom_range(3))
            0: lim = 32'hFFFF_FFFF;
            1: lim = (ph == 5) ? 32'h0 : $urandom;
            2: lim = $urandom_range(256, 65536);
            default: lim = $urandom_range(1 << 20, 1 << 28);
         endcase
         if (ph == 13) lim = 32'h0;
         set_segment(lim);
         quiet = (ph == 7);
         if (ph == 3) hold_go = 1'b1;
         for (int k = 0; k < 105; k += len) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 8);
            for (int j = 0; j < len; j++)
               send_point(pick_coord(0), pick_coord(1), pick_coord(2), j == len - 1);
         end
         drain();
      end
      quiet = 1'b0;

      $display("%0d points in %0d runs, %0d results checked over 17 segment settings",
               points_sent, runs_sent, sb.checked);
      if (sb.errors == 0 && sb.expect_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d errors, %0d results missing", sb.errors, sb.expect_q.size());
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

>>> min_point_to_segment_distance.f
rtl/mpsd_pkg.sv
rtl/mpsd_ctrl.sv
rtl/mpsd_datapath.sv
rtl/min_point_to_segment_distance.sv
verif/tb_min_point_to_segment_distance.sv
